/* rtl/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 code point decoder.
// No dependencies; used by utf8d_decode and utf8_code_point_decoder.
package utf8d_pkg;

    localparam int CP_W    = 21;
    localparam int BYTE_W  = 8;
    localparam int CONT_W  = 6;
    localparam int NEED_W  = 2;

    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_CODE = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_CODE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_CODE = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_CODE  = 8'h80;

    localparam logic [NEED_W-1:0] NEED_NONE  = 2'd0;
    localparam logic [NEED_W-1:0] NEED_ONE   = 2'd1;
    localparam logic [NEED_W-1:0] NEED_TWO   = 2'd2;
    localparam logic [NEED_W-1:0] NEED_THREE = 2'd3;

    typedef logic [CP_W-1:0] code_point_t;

    typedef struct packed {
        logic        valid;
        code_point_t code_point;
        logic        is_error;
        logic        last;
    } result_t;

endpackage

/* rtl/utf8d_decode.sv */
// Per-byte UTF-8 decode step and the decoder's sequence state.
// Depends on utf8d_pkg.
module utf8d_decode
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [utf8d_pkg::BYTE_W-1:0] data_byte,
    input  logic                       end_of_string,
    output utf8d_pkg::result_t         result
);

    logic [utf8d_pkg::NEED_W-1:0] need_reg;
    logic [utf8d_pkg::NEED_W-1:0] need_next;
    utf8d_pkg::code_point_t       part_reg;
    utf8d_pkg::code_point_t       part_next;
    logic                         failed_reg;
    logic                         failed_next;

    always_comb
    begin
        logic                         have_char;
        utf8d_pkg::code_point_t       cp;
        logic                         bad;
        logic [utf8d_pkg::NEED_W-1:0] need_w;
        utf8d_pkg::code_point_t       part_w;
        logic                         failed_w;

        need_w    = need_reg;
        part_w    = part_reg;
        failed_w  = failed_reg;
        have_char = 1'b0;
        cp        = '0;

        if (!failed_reg)
        begin
            if (need_reg == utf8d_pkg::NEED_NONE)
            begin
                priority if (!data_byte[utf8d_pkg::BYTE_W-1])
                begin
                    cp        = utf8d_pkg::code_point_t'(data_byte);
                    have_char = 1'b1;
                end
                else if ((data_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_CODE)
                begin
                    part_w = utf8d_pkg::code_point_t'(data_byte[4:0]);
                    need_w = utf8d_pkg::NEED_ONE;
                end
                else if ((data_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_CODE)
                begin
                    part_w = utf8d_pkg::code_point_t'(data_byte[3:0]);
                    need_w = utf8d_pkg::NEED_TWO;
                end
                else if ((data_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_CODE)
                begin
                    part_w = utf8d_pkg::code_point_t'(data_byte[2:0]);
                    need_w = utf8d_pkg::NEED_THREE;
                end
                else
                begin
                    failed_w = 1'b1;
                end
            end
            else if ((data_byte & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_CODE)
            begin
                // shift in six payload bits; top bits fall off the 21-bit field
                part_w = {part_reg[utf8d_pkg::CP_W-utf8d_pkg::CONT_W-1:0],
                          data_byte[utf8d_pkg::CONT_W-1:0]};
                need_w = need_reg - utf8d_pkg::NEED_ONE;
                if (need_w == utf8d_pkg::NEED_NONE)
                begin
                    cp        = part_w;
                    have_char = 1'b1;
                    part_w    = '0;
                end
            end
            else
            begin
                failed_w = 1'b1;
            end
        end

        bad = failed_w || (need_w != utf8d_pkg::NEED_NONE);

        if (end_of_string)
        begin
            need_next   = utf8d_pkg::NEED_NONE;
            part_next   = '0;
            failed_next = 1'b0;
            result.valid      = bad || have_char;
            result.code_point = bad ? '0 : cp;
            result.is_error   = bad;
            result.last       = 1'b1;
        end
        else
        begin
            need_next   = need_w;
            part_next   = part_w;
            failed_next = failed_w;
            result.valid      = have_char;
            result.code_point = cp;
            result.is_error   = 1'b0;
            result.last       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg   <= utf8d_pkg::NEED_NONE;
            part_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else if (advance)
        begin
            need_reg   <= need_next;
            part_reg   <= part_next;
            failed_reg <= failed_next;
        end
    end

endmodule

/* rtl/utf8_code_point_decoder.sv */
// Top level of the UTF-8 code point decoder: input register, decode step,
// result register. Depends on utf8d_pkg and utf8d_decode.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+--------------------------------
//  bytes   | byte_valid  | byte_stall  | data_byte, end_of_string
//  chars   | char_valid  | char_stall  | code_point, is_error, last
//
// One byte is taken per clock while byte_stall is low. A byte is held in
// the input register, is decoded against the sequence state and lands in
// the result register, which offers a character once its final byte lands.
// rst_n clears both registers' valid flags and the sequence state.
// A byte that yields no result never waits on char_stall; a byte with a
// result holds in the input register only while the result register is
// full and stalled, and byte_stall rises exactly then.
module utf8_code_point_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_string,

    output logic        char_valid,
    input  logic        char_stall,
    output logic [20:0] code_point,
    output logic        is_error,
    output logic        last
);

    // input register
    logic                             in_valid_reg;
    logic [utf8d_pkg::BYTE_W-1:0]     in_byte_reg;
    logic                             in_eos_reg;

    // result register
    logic                             res_valid_reg;
    utf8d_pkg::code_point_t           res_cp_reg;
    logic                             res_err_reg;
    logic                             res_last_reg;

    utf8d_pkg::result_t               step_result;
    logic                             advance;
    logic                             accept;

    utf8d_decode u_decode
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .data_byte     (in_byte_reg),
        .end_of_string (in_eos_reg),
        .result        (step_result)
    );

    // Advance the held byte unless its result would overwrite a stalled one.
    assign advance    = in_valid_reg
                        && !(step_result.valid && res_valid_reg && char_stall);
    assign byte_stall = in_valid_reg && !advance;
    assign accept     = byte_valid && !byte_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= data_byte;
            in_eos_reg  <= end_of_string;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance && step_result.valid)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!char_stall)
        begin
            // drop the beat once taken
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && step_result.valid)
        begin
            res_cp_reg   <= step_result.code_point;
            res_err_reg  <= step_result.is_error;
            res_last_reg <= step_result.last;
        end
    end

    assign char_valid = res_valid_reg;
    assign code_point = res_cp_reg;
    assign is_error   = res_err_reg;
    assign last       = res_last_reg;

endmodule
